// ===== src/mffu_pkg.sv =====
// Package for the maze flood-fill update unit: sizes, op codes, FSM states.
// No dependencies.
package mffu_pkg;
    localparam int GRID_BITS = 4;
    localparam int CELL_BITS = 2 * GRID_BITS;
    localparam int NCELLS    = 1 << CELL_BITS;
    localparam int DIST_W    = 10;
    localparam int SP_BITS   = CELL_BITS + 1;
    localparam logic [DIST_W-1:0] DMAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        OP_WALL  = 2'd0,
        OP_WDIST = 2'd1,
        OP_RDIST = 2'd2,
        OP_FLOOD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_SIMPLE, ST_CUR_RD, ST_CUR_WT, ST_NBR_RD, ST_NBR_EV,
        ST_PREV_RD, ST_SREPAIR, ST_CLEAR, ST_SEED, ST_PUSH_RD, ST_PUSH_EV,
        ST_POP, ST_POP_WT, ST_CHK_EV, ST_FIX, ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input transaction
        logic       init_step; // zero one entry of the wall, distance and visited stores after reset
        logic       clr_step;  // clear one visited entry
        logic       do_simple; // ops 0..2
        logic       sel_pop;   // current cell := popped cell
        logic       lat_cur;   // latch current cell wall/dist
        logic       rd_nbr;    // read neighbour dir
        logic [1:0] dir;
        logic       rd_prev;   // read previous cell dist
        logic       acc_init;  // reset min/consistent accumulators
        logic       acc_step;  // fold neighbour into accumulators
        logic       wr_prev1;  // current := prev+1 (sat)
        logic       wr_min1;   // current := min+1 (sat)
        logic       push_cur;  // push current cell
        logic       push_nbr;  // push neighbour if open & unvisited
        logic       pop;       // pop top of stack
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        op_t        op;
        logic       consistent;
        logic       stack_empty;
        logic       clr_last;
    } stat_t;

    function automatic logic blocked(input logic [1:0] d, input logic [3:0] code);
        logic [15:0] m;
        begin
            case (d)
                DIR_N:   m = 16'h7584;
                DIR_E:   m = 16'h3AC8;
                DIR_S:   m = 16'h5C70;
                default: m = 16'h6B22;
            endcase
            blocked = m[code];
        end
    endfunction
endpackage

// ===== src/mffu_ctrl.sv =====
// Sequencer for the maze flood-fill update unit.
// Depends on mffu_pkg.
module mffu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  mffu_pkg::stat_t st,
    output mffu_pkg::ctrl_t cmd
);
    import mffu_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] dir_reg, dir_next;
    logic       ret_reg, ret_next; // 0: start check, 1: pop check

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            dir_reg   <= DIR_N;
            ret_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            ret_reg   <= ret_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        dir_next   = dir_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_INIT: begin
                if (st.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_SIMPLE;
            end
            ST_SIMPLE: begin
                if (st.op == OP_FLOOD) begin
                    state_next = ST_CUR_RD;
                    ret_next   = 1'b0;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_CUR_RD:  state_next = ST_CUR_WT;
            ST_CUR_WT: begin
                state_next = ST_NBR_RD;
                dir_next   = DIR_N;
            end
            ST_NBR_RD:  state_next = ST_NBR_EV;
            ST_NBR_EV: begin
                if (dir_reg == DIR_W) state_next = ret_reg ? ST_CHK_EV : ST_PREV_RD;
                else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_NBR_RD;
                end
            end
            ST_PREV_RD: state_next = ST_SREPAIR;
            ST_SREPAIR: state_next = ST_CLEAR;
            ST_CLEAR: begin
                if (st.clr_last) state_next = ST_SEED;
            end
            ST_SEED: begin
                state_next = ST_PUSH_RD;
                dir_next   = DIR_N;
            end
            ST_PUSH_RD: state_next = ST_PUSH_EV;
            ST_PUSH_EV: begin
                if (dir_reg == DIR_W) state_next = ST_POP;
                else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_PUSH_RD;
                end
            end
            ST_POP: begin
                state_next = st.stack_empty ? ST_OUT : ST_POP_WT;
            end
            ST_POP_WT: begin
                state_next = ST_CUR_RD;
                ret_next   = 1'b1;
            end
            ST_CHK_EV:  state_next = st.consistent ? ST_POP : ST_FIX;
            ST_FIX: begin
                state_next = ST_PUSH_RD;
                dir_next   = DIR_N;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        cmd.dir = dir_reg;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_INIT:    cmd.init_step = 1'b1;
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SIMPLE:  cmd.do_simple = 1'b1;
            ST_CUR_RD:  cmd.acc_init = 1'b1;
            ST_CUR_WT:  cmd.lat_cur = 1'b1;
            ST_NBR_RD:  cmd.rd_nbr = 1'b1;
            ST_NBR_EV:  cmd.acc_step = 1'b1;
            ST_PREV_RD: cmd.rd_prev = 1'b1;
            ST_SREPAIR: cmd.wr_prev1 = !st.consistent;
            ST_CLEAR:   cmd.clr_step = 1'b1;
            ST_SEED:    cmd.push_cur = 1'b1;
            ST_PUSH_RD: cmd.rd_nbr = 1'b1;
            ST_PUSH_EV: cmd.push_nbr = 1'b1;
            ST_POP:     cmd.pop = !st.stack_empty;
            ST_POP_WT:  cmd.sel_pop = 1'b1;
            ST_FIX:     cmd.wr_min1 = 1'b1;
            ST_OUT:     m_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== src/mffu_dp.sv =====
// Datapath for the maze flood-fill update unit: grid stores, visited map, stack.
// Depends on mffu_pkg.
module mffu_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mffu_pkg::ctrl_t         cmd,
    output mffu_pkg::stat_t         st,
    input  logic [1:0]              s_op,
    input  logic [3:0]              s_cell_x,
    input  logic [3:0]              s_cell_y,
    input  logic [3:0]              s_prev_x,
    input  logic [3:0]              s_prev_y,
    input  logic [3:0]              s_wall_code,
    input  logic [9:0]              s_distance_in,
    output logic [9:0]              m_distance_out
);
    import mffu_pkg::*;

    logic [3:0]           wall_mem  [NCELLS];
    logic [DIST_W-1:0]    dist_mem  [NCELLS];
    logic                 vis_mem   [NCELLS];
    logic [CELL_BITS-1:0] stack_mem [NCELLS];

    op_t                  op_reg;
    logic [GRID_BITS-1:0] px_reg, py_reg, curx_reg, cury_reg;
    logic [3:0]           wc_reg, curw_reg, rwall_reg;
    logic [DIST_W-1:0]    din_reg, curd_reg, min_reg, rdist_reg;
    logic                 cons_reg, nopen_reg, rvis_reg, dout_sel_reg;
    logic [CELL_BITS-1:0] clr_reg, nbr_reg, rstack_reg;
    logic [SP_BITS-1:0]   sp_reg;

    // neighbour geometry
    logic [GRID_BITS-1:0] nx, ny;
    logic                 on_grid;
    always_comb begin
        nx = curx_reg;
        ny = cury_reg;
        on_grid = 1'b1;
        case (cmd.dir)
            DIR_N: begin on_grid = (cury_reg != '1); ny = cury_reg + 1'b1; end
            DIR_E: begin on_grid = (curx_reg != '1); nx = curx_reg + 1'b1; end
            DIR_S: begin on_grid = (cury_reg != '0); ny = cury_reg - 1'b1; end
            default: begin on_grid = (curx_reg != '0); nx = curx_reg - 1'b1; end
        endcase
    end

    logic open_now;
    assign open_now = on_grid && !blocked(cmd.dir, curw_reg);

    logic [CELL_BITS-1:0] cur_idx, nbr_idx, prev_idx, dist_ra;
    logic [SP_BITS-1:0]   sp_m1;
    logic [DIST_W-1:0]    dm1;
    assign cur_idx  = {curx_reg, cury_reg};
    assign nbr_idx  = {nx, ny};
    assign prev_idx = {px_reg, py_reg};
    assign sp_m1    = sp_reg - 1'b1;
    assign dm1      = curd_reg - 1'b1;

    always_comb begin
        dist_ra = cur_idx;
        if (cmd.rd_prev) dist_ra = prev_idx;
        else if (cmd.rd_nbr) dist_ra = nbr_idx;
    end

    // write port muxes
    logic                 push_nbr_ok;
    logic                 wall_we, dist_we, vis_we, stk_we;
    logic [CELL_BITS-1:0] wall_wa, dist_wa, vis_wa, stk_wd;
    logic [3:0]           wall_wd;
    logic [DIST_W-1:0]    dist_wd;
    logic                 vis_wd;

    assign push_nbr_ok = cmd.push_nbr && nopen_reg && !rvis_reg;
    assign stk_we      = (cmd.push_cur || push_nbr_ok) && !sp_reg[SP_BITS-1];
    assign stk_wd      = cmd.push_cur ? cur_idx : nbr_reg;

    always_comb begin
        wall_we = 1'b0;
        wall_wa = cur_idx;
        wall_wd = wc_reg;
        if (cmd.init_step) begin
            wall_we = 1'b1;
            wall_wa = clr_reg;
            wall_wd = '0;
        end else if (cmd.do_simple && op_reg == OP_WALL) begin
            wall_we = 1'b1;
        end
    end

    always_comb begin
        dist_we = 1'b0;
        dist_wa = cur_idx;
        dist_wd = din_reg;
        if (cmd.init_step) begin
            dist_we = 1'b1;
            dist_wa = clr_reg;
            dist_wd = '0;
        end else if (cmd.do_simple && op_reg == OP_WDIST) begin
            dist_we = 1'b1;
        end else if (cmd.wr_prev1) begin
            dist_we = 1'b1;
            dist_wd = (rdist_reg == DMAX) ? DMAX : rdist_reg + 1'b1;
        end else if (cmd.wr_min1) begin
            dist_we = 1'b1;
            dist_wd = (min_reg == DMAX) ? DMAX : min_reg + 1'b1;
        end
    end

    always_comb begin
        vis_we = 1'b0;
        vis_wa = clr_reg;
        vis_wd = 1'b0;
        if (cmd.init_step || cmd.clr_step) begin
            vis_we = 1'b1;
        end else if (cmd.push_cur) begin
            vis_we = 1'b1;
            vis_wa = cur_idx;
            vis_wd = 1'b1;
        end else if (push_nbr_ok) begin
            vis_we = 1'b1;
            vis_wa = nbr_reg;
            vis_wd = 1'b1;
        end
    end

    // stores: one write and registered reads
    always_ff @(posedge aclk) begin
        if (wall_we) wall_mem[wall_wa] <= wall_wd;
        if (dist_we) dist_mem[dist_wa] <= dist_wd;
        if (vis_we)  vis_mem[vis_wa]   <= vis_wd;
        if (stk_we)  stack_mem[sp_reg[CELL_BITS-1:0]] <= stk_wd;
        rwall_reg  <= wall_mem[cur_idx];
        rdist_reg  <= dist_mem[dist_ra];
        rvis_reg   <= vis_mem[nbr_idx];
        rstack_reg <= stack_mem[sp_m1[CELL_BITS-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg  <= '0;
            clr_reg <= '0;
        end else begin
            if (cmd.load) begin
                op_reg   <= op_t'(s_op);
                curx_reg <= s_cell_x;
                cury_reg <= s_cell_y;
                px_reg   <= s_prev_x;
                py_reg   <= s_prev_y;
                wc_reg   <= s_wall_code;
                din_reg  <= s_distance_in[DIST_W-1:0];
            end
            if (cmd.sel_pop) begin
                curx_reg <= rstack_reg[CELL_BITS-1:GRID_BITS];
                cury_reg <= rstack_reg[GRID_BITS-1:0];
            end
            if (cmd.do_simple) dout_sel_reg <= (op_reg == OP_RDIST);
            if (cmd.lat_cur) begin
                curw_reg <= rwall_reg;
                curd_reg <= rdist_reg;
            end
            if (cmd.rd_nbr) begin
                nopen_reg <= open_now;
                nbr_reg   <= nbr_idx;
            end
            if (cmd.acc_init) begin
                min_reg  <= DMAX;
                cons_reg <= 1'b0;
            end else if (cmd.acc_step && nopen_reg) begin
                if (rdist_reg < min_reg) min_reg <= rdist_reg;
                if (rdist_reg == dm1) cons_reg <= 1'b1;
            end
            if (cmd.init_step || cmd.clr_step) clr_reg <= clr_reg + 1'b1;
            if (stk_we) sp_reg <= sp_reg + 1'b1;
            else if (cmd.pop) sp_reg <= sp_m1;
        end
    end

    always_comb begin
        st             = '0;
        st.op          = op_reg;
        st.consistent  = (curd_reg == '0) || cons_reg;
        st.stack_empty = (sp_reg == '0);
        st.clr_last    = (clr_reg == '1);
    end

    // read result stays on the addressed cell while the result waits
    assign m_distance_out = dout_sel_reg ? rdist_reg : '0;
endmodule

// ===== src/maze_flood_fill_update_unit.sv =====
// Top level of the maze flood-fill update unit.
// Depends on mffu_pkg, mffu_ctrl, mffu_dp.
//
//  channel | ports                                          | dir
//  s_      | s_valid s_ready s_op s_cell_x/y s_prev_x/y     | in
//          | s_wall_code s_distance_in                      |
//  m_      | m_valid m_ready m_distance_out m_done_res      | out
//
// After reset a sweep zeroes every entry of the wall, distance and visited stores;
// s_ready stays low meanwhile. Ops 0..2 pass through accept, execute and result states.
// A flood update checks and repairs the start cell, sweeps the visited map, then pushes
// and pops cells, repairing each inconsistent one; the sweep is most of a short update.
// One transaction in flight; s_ready low while busy or while a result waits.
module maze_flood_fill_update_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [3:0] s_cell_x,
    input  logic [3:0] s_cell_y,
    input  logic [3:0] s_prev_x,
    input  logic [3:0] s_prev_y,
    input  logic [3:0] s_wall_code,
    input  logic [9:0] s_distance_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [9:0] m_distance_out,
    output logic       m_done_res
);
    import mffu_pkg::*;

    ctrl_t cmd;
    stat_t st;

    mffu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .st(st), .cmd(cmd)
    );

    mffu_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st),
        .s_op(s_op), .s_cell_x(s_cell_x), .s_cell_y(s_cell_y),
        .s_prev_x(s_prev_x), .s_prev_y(s_prev_y), .s_wall_code(s_wall_code),
        .s_distance_in(s_distance_in), .m_distance_out(m_distance_out)
    );

    assign m_done_res = 1'b1;
endmodule
